// ===== rtl/core/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg
// Shared constants, types and control codes of the stereo linear resampler.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_RESULTS  = 64;
  localparam int CNT_W        = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_OUT
  } srs_state_e;

  typedef struct packed {
    logic shift;
    logic mul;
    logic load;
    logic last;
  } srs_ctl_t;

endpackage

// ===== rtl/core/srs_in_if.sv =====
// ----------------------------------------------------------------------------
// srs_in_if
// Input channel: one stereo sample pair per item.
// ----------------------------------------------------------------------------
interface srs_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_left;
  logic signed [SAMPLE_WIDTH-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

// ===== rtl/core/srs_out_if.sv =====
// ----------------------------------------------------------------------------
// srs_out_if
// Output channel: one interpolated stereo pair per item, with end-of-run flag.
// ----------------------------------------------------------------------------
interface srs_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_left;
  logic signed [SAMPLE_WIDTH-1:0] out_right;
  logic                           last_of_run;

  modport source (output valid, output out_left, output out_right, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_left, input out_right, input last_of_run,
                  output ready);
endinterface

// ===== rtl/core/stereo_linear_resampler_top.sv =====
// ----------------------------------------------------------------------------
// stereo_linear_resampler_top
// Linear-interpolation sample rate converter for one stereo stream.
//
// in_i takes one stereo sample pair per item; out_o gives the interpolated
// pairs it produces, last_of_run marking the final one for that input item.
// cfg_we_i/cfg_data_i write the rate ratio (input over output rate, unsigned
// with FRAC_BITS fraction bits); write it only while the block is idle.
// An input item is taken in S_IDLE. Each output then passes through the
// per-output sequence: phase test in S_CHECK, one registered multiply per
// lane, then the rounding add into the output register in S_MUL; out_o.valid
// rises with that load and stays high in S_OUT until the item is taken, and
// the next output of the same run starts again at S_CHECK. An input item
// that causes no output raises in_i.ready again when S_CHECK returns to
// S_IDLE.
// One input item is in flight at a time; in_i.ready stays low until its run
// is fully delivered. A stalled receiver holds the output register and the
// whole run. Reset clears the samples to zero, sets the phase to 2.0 and the
// ratio to 1.0.
// ----------------------------------------------------------------------------
module stereo_linear_resampler_top
  import srs_pkg::*;
#(
  parameter int FRAC_BITS    = srs_pkg::FRAC_BITS,
  parameter int SAMPLE_WIDTH = srs_pkg::SAMPLE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [FRAC_BITS+2:0]   cfg_data_i,
  srs_in_if.sink                 in_i,
  srs_out_if.source              out_o
);

  srs_ctl_t                       ctl;
  logic        [FRAC_BITS-1:0]    frac;
  logic                           done;
  logic signed [SAMPLE_WIDTH-1:0] left_res, right_res;

  srs_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_done_i (done),
    .ctl_o      (ctl),
    .frac_o     (frac)
  );

  srs_lane #(
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .frac_i   (frac),
    .sample_i (in_i.in_left),
    .result_o (left_res)
  );

  srs_lane #(
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .frac_i   (frac),
    .sample_i (in_i.in_right),
    .result_o (right_res)
  );

  srs_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .left_i  (left_res),
    .right_i (right_res),
    .done_o  (done),
    .out_o   (out_o)
  );

endmodule

// ===== rtl/core/srs_lane.sv =====
// ----------------------------------------------------------------------------
// srs_lane
// One channel: sample history, registered product and rounded interpolation.
// ----------------------------------------------------------------------------
module srs_lane
  import srs_pkg::*;
#(
  parameter int FRAC_BITS    = srs_pkg::FRAC_BITS,
  parameter int SAMPLE_WIDTH = srs_pkg::SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srs_ctl_t                       ctl_i,
  input  logic        [FRAC_BITS-1:0]    frac_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] result_o
);

  localparam int VW = SAMPLE_WIDTH + FRAC_BITS + 2;
  localparam logic signed [VW-1:0] Half = VW'(1) <<< (FRAC_BITS - 1);

  logic signed [SAMPLE_WIDTH-1:0] prev_q, cur_q;
  logic signed [VW-1:0]           prod_q, prod_d;
  logic signed [SAMPLE_WIDTH:0]   diff;
  logic signed [VW-1:0]           base, v, rnd;

  assign diff   = {cur_q[SAMPLE_WIDTH-1], cur_q} - {prev_q[SAMPLE_WIDTH-1], prev_q};
  assign prod_d = VW'(diff * $signed({1'b0, frac_i}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cur_q  <= '0;
    end else if (ctl_i.shift) begin
      prev_q <= cur_q;
      cur_q  <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= prod_d;
    end
  end

  // round half away from zero: bias by half, one less for negative values
  assign base     = {{2{prev_q[SAMPLE_WIDTH-1]}}, prev_q, {FRAC_BITS{1'b0}}};
  assign v        = base + prod_q;
  assign rnd      = (v + Half - VW'(v[VW-1])) >>> FRAC_BITS;
  assign result_o = rnd[SAMPLE_WIDTH-1:0];

endmodule

// ===== rtl/core/srs_merge.sv =====
// ----------------------------------------------------------------------------
// srs_merge
// Output register joining both lanes and the end-of-run flag into one item.
// ----------------------------------------------------------------------------
module srs_merge
  import srs_pkg::*;
#(
  parameter int SAMPLE_WIDTH = srs_pkg::SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srs_ctl_t                       ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] left_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_i,
  output logic                           done_o,
  srs_out_if.source                      out_o
);

  logic                           valid_q;
  logic                           last_q;
  logic signed [SAMPLE_WIDTH-1:0] left_q, right_q;

  assign done_o = valid_q & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end else if (done_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      left_q  <= left_i;
      right_q <= right_i;
      last_q  <= ctl_i.last;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_left    = left_q;
  assign out_o.out_right   = right_q;
  assign out_o.last_of_run = last_q;

endmodule

// ===== rtl/core/srs_ctrl.sv =====
// ----------------------------------------------------------------------------
// srs_ctrl
// Phase accumulator, ratio register, run counter and sequencing of the lanes.
// ----------------------------------------------------------------------------
module srs_ctrl
  import srs_pkg::*;
#(
  parameter int FRAC_BITS = srs_pkg::FRAC_BITS,
  localparam int PW       = FRAC_BITS + 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [PW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_done_i,
  output srs_ctl_t             ctl_o,
  output logic [FRAC_BITS-1:0] frac_o
);

  localparam logic [PW-1:0] PhaseOne = {3'b001, {FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] PhaseTwo = {3'b010, {FRAC_BITS{1'b0}}};

  srs_state_e       state_q, state_d;
  logic [PW-1:0]    phase_q, phase_d, ratio_q, adv;
  logic [PW:0]      sum;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             below_one;

  assign below_one = (phase_q[PW-1:FRAC_BITS] == 3'b000);
  assign sum       = {1'b0, phase_q} + {1'b0, ratio_q};
  assign adv       = sum[PW] ? {PW{1'b1}} : sum[PW-1:0];
  assign frac_o    = phase_q[FRAC_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PhaseTwo;
      ratio_q <= PhaseOne;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      if (cfg_we_i) begin
        ratio_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.shift = 1'b1;
          phase_d     = below_one ? '0 : phase_q - PhaseOne;
          cnt_d       = '0;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (below_one) begin
          ctl_o.mul = 1'b1;
          last_d    = (adv[PW-1:FRAC_BITS] != 3'b000) ||
                      (cnt_q == CNT_W'(MAX_RESULTS - 1));
          phase_d   = adv;
          cnt_d     = cnt_q + 1'b1;
          state_d   = S_MUL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        ctl_o.load = 1'b1;
        ctl_o.last = last_q;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_done_i) begin
          state_d = last_q ? S_IDLE : S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/srs_checker.sv =====
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks of the resampler handshakes and sequencing.
// ----------------------------------------------------------------------------
module srs_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] out_left_i,
  input logic [SAMPLE_WIDTH-1:0] out_right_i,
  input logic                    out_last_i
);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i & in_ready_i;
  assign out_acc = out_valid_i & out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_left_i) && $stable(out_right_i) && $stable(out_last_i))
    else $error("output item changed while stalled");

  a_one_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input taken while a run is still being delivered");

  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i && !out_valid_i)
    else $error("block not busy after taking an input item");

  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> !out_valid_i)
    else $error("output register not emptied after delivery");

endmodule

bind stereo_linear_resampler_top srs_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_srs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.out_left),
  .out_right_i (out_o.out_right),
  .out_last_i  (out_o.last_of_run)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for stereo_linear_resampler_top. A behavioral phase accumulator
// and interpolator predicts every output pair from each accepted input item.
// A scoreboard checks the pairs in order. Directed tests cover sample
// extremes, half-way rounding, the ratio bounds, and zero, tiny and saturating
// ratios. Random segments then follow under random sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import srs_pkg::*;

  localparam int PHASE_W         = FRAC_BITS + 3;
  localparam int PHASE_ONE       = 1 << FRAC_BITS;
  localparam int PHASE_MAX       = (1 << PHASE_W) - 1;
  localparam int RATIO_MIN       = 1024;
  localparam int RATIO_MAX       = 262144;
  localparam int WATCHDOG_CYCLES = 2000;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [PHASE_W-1:0]             phase_t;

  typedef struct packed {
    sample_t left_s;
    sample_t right_s;
    logic    last_s;
  } out_pair_t;

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we;
  phase_t cfg_data;

  srs_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) in_if ();
  srs_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) out_if ();

  stereo_linear_resampler_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  out_pair_t pending_pairs[$];
  phase_t    phase_acc   = phase_t'(2 * PHASE_ONE);
  phase_t    rate_ratio  = phase_t'(PHASE_ONE);
  sample_t   prev_left   = '0;
  sample_t   cur_left    = '0;
  sample_t   prev_right  = '0;
  sample_t   cur_right   = '0;
  int        fail_count  = 0;
  int        burst_left  = 0;
  bit        tx_gaps     = 1'b1;
  int        idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic sample_t lerp_round(input sample_t a, input sample_t b, input phase_t t);
    longint acc;
    longint mag;
    acc = longint'(a) * (longint'(1) <<< FRAC_BITS) + (longint'(b) - longint'(a)) * longint'(t);
    mag = (acc < 0) ? -acc : acc;
    mag = (mag + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sample_t'((acc < 0) ? -mag : mag);
  endfunction

  task automatic predict_output_pairs(input sample_t l, input sample_t r);
    out_pair_t pair;
    int        n;
    longint    next_phase;
    n = 0;
    phase_acc  = (phase_acc >= PHASE_ONE) ? phase_t'(phase_acc - PHASE_ONE) : '0;
    prev_left  = cur_left;
    cur_left   = l;
    prev_right = cur_right;
    cur_right  = r;
    while (phase_acc < PHASE_ONE && n < MAX_RESULTS) begin
      pair.left_s  = lerp_round(prev_left, cur_left, phase_acc);
      pair.right_s = lerp_round(prev_right, cur_right, phase_acc);
      next_phase   = longint'(phase_acc) + longint'(rate_ratio);
      phase_acc    = (next_phase > PHASE_MAX) ? phase_t'(PHASE_MAX) : phase_t'(next_phase);
      n++;
      pair.last_s  = !(phase_acc < PHASE_ONE && n < MAX_RESULTS);
      pending_pairs.push_back(pair);
    end
  endtask

  task automatic send_pair(input sample_t l, input sample_t r);
    int gap;
    if (burst_left == 0) begin
      gap = tx_gaps ? $urandom_range(1, 6) : 0;
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.in_left  <= l;
    in_if.in_right <= r;
    do @(posedge clk_i); while (!in_if.ready);
    predict_output_pairs(l, r);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_pairs.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_ratio(input phase_t value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    rate_ratio = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return sample_t'(32767);
      1: return sample_t'(-32768);
      2: return sample_t'(int'($urandom_range(0, 16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic phase_t pick_ratio();
    case ($urandom_range(0, 9))
      0: return phase_t'($urandom_range(RATIO_MIN, 4096));
      1: return phase_t'(RATIO_MAX);
      2: return phase_t'($urandom_range(0, RATIO_MIN - 1));
      3: return phase_t'($urandom_range(RATIO_MAX + 1, PHASE_MAX));
      4: return phase_t'(RATIO_MIN);
      default: return phase_t'($urandom_range(16384, 131072));
    endcase
  endfunction

  task automatic test_unity_ratio();
    send_pair(sample_t'(32767), sample_t'(-32768));
    send_pair(sample_t'(-32768), sample_t'(32767));
    send_pair(sample_t'(0), sample_t'(-1));
    send_pair(sample_t'(-1), sample_t'(1));
    send_pair(sample_t'(32767), sample_t'(32767));
  endtask

  task automatic test_half_rounding();
    set_ratio(phase_t'(PHASE_ONE / 2));
    send_pair(sample_t'(1), sample_t'(-1));
    send_pair(sample_t'(0), sample_t'(0));
    send_pair(sample_t'(-1), sample_t'(1));
    send_pair(sample_t'(-32768), sample_t'(32767));
  endtask

  task automatic test_ratio_bounds();
    set_ratio(phase_t'(RATIO_MIN));
    send_pair(sample_t'(32767), sample_t'(-32768));
    send_pair(sample_t'(-32768), sample_t'(32767));
    set_ratio(phase_t'(RATIO_MAX));
    send_pair(sample_t'(100), sample_t'(-100));
    send_pair(sample_t'(-32768), sample_t'(-32768));
    send_pair(sample_t'(32767), sample_t'(0));
    send_pair(sample_t'(-5), sample_t'(5));
  endtask

  task automatic test_ratio_outside();
    set_ratio('0);
    send_pair(sample_t'(1234), sample_t'(-4321));
    send_pair(sample_t'(-32768), sample_t'(32767));
    send_pair(sample_t'(7), sample_t'(-7));
    set_ratio(phase_t'(1));
    send_pair(sample_t'(32767), sample_t'(-32768));
    set_ratio(phase_t'(PHASE_MAX));
    repeat (7) send_pair(pick_sample(), pick_sample());
  endtask

  task automatic test_random_stream();
    for (int seg = 0; seg < 10; seg++) begin
      set_ratio(pick_ratio());
      tx_gaps = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 12; i++) begin
        if (i == 7 && $urandom_range(0, 2) == 0) drain_results();
        send_pair(pick_sample(), pick_sample());
      end
    end
  endtask

  initial begin
    int rx_mode;
    int rx_left;
    int rx_hold;
    rx_mode = 0;
    rx_left = 0;
    rx_hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 80);
      end
      rx_left--;
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_if.ready <= 1'b1;
        case (rx_mode)
          0: rx_hold = 0;
          1: rx_hold = $urandom_range(0, 1);
          2: rx_hold = $urandom_range(0, 4);
          default: rx_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    out_pair_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected output pair: left %0d right %0d", out_if.out_left, out_if.out_right);
        fail_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_if.out_left !== want.left_s) begin
          $error("out_left: expected %0d, got %0d", want.left_s, out_if.out_left);
          fail_count++;
        end
        if (out_if.out_right !== want.right_s) begin
          $error("out_right: expected %0d, got %0d", want.right_s, out_if.out_right);
          fail_count++;
        end
        if (out_if.last_of_run !== want.last_s) begin
          $error("last_of_run: expected %0d, got %0d", want.last_s, out_if.last_of_run);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.in_left  = '0;
    in_if.in_right = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_unity_ratio();
    test_half_rounding();
    test_ratio_bounds();
    test_ratio_outside();
    test_random_stream();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
